/* rtl/core/cpfp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Checksummed position frame parser package
// Shared types and protocol constants for the frame parser modules.
// ----------------------------------------------------------------------------
package cpfp_pkg;

   localparam logic [7:0]  HEADER_BYTE       = 8'hA5;
   localparam logic [7:0]  TAIL_BYTE         = 8'h5A;
   localparam logic [15:0] ABSENT_POS        = 16'hFFFF;
   localparam logic [7:0]  FIELD_COUNT       = 8'd6;
   localparam logic [7:0]  PAYLOAD_LEN_RESET = 8'd6;

   // Parser phase, one-hot.
   typedef enum logic [3:0] {
      PH_HUNT    = 4'b0001,
      PH_PAYLOAD = 4'b0010,
      PH_CHECK   = 4'b0100,
      PH_TAIL    = 4'b1000
   } cpfp_phase_type;

   // One decoded frame plus the flag that says this word completes a good frame.
   typedef struct packed {
      logic               emit;
      logic [15:0]        pos_x;
      logic [15:0]        pos_y;
      logic [15:0]        span_value;
      logic signed [15:0] delta_x_out;
      logic signed [15:0] delta_y_out;
      logic               x_updated;
      logic               y_updated;
   } cpfp_result_type;

endpackage

/* rtl/core/cpfp_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame parser core
// Walks header, payload, checksum and tail one word per cycle while go is high
// and builds the decoded result when a frame closes with a good tail.
// ----------------------------------------------------------------------------
module cpfp_parser (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     go,
   input  logic [7:0]               rx_byte,
   input  logic [7:0]               payload_len,
   output cpfp_pkg::cpfp_result_type res
);

   cpfp_pkg::cpfp_phase_type phase_ff, phase_in;
   logic [7:0]  count_ff, count_in;
   logic [7:0]  sum_ff, sum_in;
   logic [15:0] held_x_ff, held_x_in;
   logic [15:0] held_y_ff, held_y_in;
   logic [7:0]  field_ff [6];
   logic        field_we;
   logic [7:0]  len_eff;
   logic [15:0] pos_x;
   logic [15:0] pos_y;
   logic        ux;
   logic        uy;

   // Lengths below six still fill all six field bytes.
   assign len_eff = (payload_len < cpfp_pkg::FIELD_COUNT) ? cpfp_pkg::FIELD_COUNT : payload_len;
   assign pos_x   = {field_ff[0], field_ff[1]};
   assign pos_y   = {field_ff[2], field_ff[3]};
   assign ux      = (pos_x != cpfp_pkg::ABSENT_POS);
   assign uy      = (pos_y != cpfp_pkg::ABSENT_POS);

   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      sum_in    = sum_ff;
      held_x_in = held_x_ff;
      held_y_in = held_y_ff;
      field_we  = 1'b0;
      res.emit  = 1'b0;
      case (phase_ff)
         cpfp_pkg::PH_HUNT: begin
            if (rx_byte == cpfp_pkg::HEADER_BYTE) begin
               phase_in = cpfp_pkg::PH_PAYLOAD;
               count_in = 8'd0;
               sum_in   = 8'd0;
            end
         end
         cpfp_pkg::PH_PAYLOAD: begin
            field_we = (count_ff < cpfp_pkg::FIELD_COUNT);
            sum_in   = sum_ff + rx_byte;
            count_in = count_ff + 8'd1;
            if (count_in == len_eff) begin
               phase_in = cpfp_pkg::PH_CHECK;
            end
         end
         cpfp_pkg::PH_CHECK: begin
            count_in = 8'd0;
            if (rx_byte == sum_ff) begin
               phase_in = cpfp_pkg::PH_TAIL;
            end else begin
               phase_in = cpfp_pkg::PH_HUNT;
               sum_in   = 8'd0;
            end
         end
         cpfp_pkg::PH_TAIL: begin
            phase_in = cpfp_pkg::PH_HUNT;
            count_in = 8'd0;
            sum_in   = 8'd0;
            if (rx_byte == cpfp_pkg::TAIL_BYTE) begin
               res.emit = 1'b1;
               if (ux) begin
                  held_x_in = pos_x;
               end
               if (uy) begin
                  held_y_in = pos_y;
               end
            end
         end
         default: begin
            phase_in = cpfp_pkg::PH_HUNT;
            count_in = 8'd0;
            sum_in   = 8'd0;
         end
      endcase
      res.pos_x       = pos_x;
      res.pos_y       = pos_y;
      res.span_value  = {field_ff[4], field_ff[5]};
      res.delta_x_out = held_x_in;
      res.delta_y_out = held_y_in;
      res.x_updated   = ux;
      res.y_updated   = uy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= cpfp_pkg::PH_HUNT;
         count_ff  <= 8'd0;
         sum_ff    <= 8'd0;
         held_x_ff <= 16'd0;
         held_y_ff <= 16'd0;
      end else if (go) begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         sum_ff    <= sum_in;
         held_x_ff <= held_x_in;
         held_y_ff <= held_y_in;
      end
   end

   always_ff @(posedge clock) begin
      if (go && field_we) begin
         field_ff[count_ff[2:0]] <= rx_byte;
      end
   end

   // While hunting, the frame counters are always clean.
   a_hunt_clean: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == cpfp_pkg::PH_HUNT) |-> (count_ff == 8'd0 && sum_ff == 8'd0))
      else $error("parser hunting with stale count or sum");

   // A result can only come from the tail word.
   a_emit_tail: assert property (@(posedge clock) disable iff (reset)
      res.emit |-> (phase_ff == cpfp_pkg::PH_TAIL))
      else $error("result raised outside the tail phase");

   // Whatever the tail word is, the parser goes back to hunting.
   a_tail_restart: assert property (@(posedge clock) disable iff (reset)
      (go && phase_ff == cpfp_pkg::PH_TAIL) |=> (phase_ff == cpfp_pkg::PH_HUNT))
      else $error("parser did not restart after the tail word");

endmodule

/* rtl/core/cpfp_out_reg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result register
// Holds one decoded frame until the receiver takes it.
// ----------------------------------------------------------------------------
module cpfp_out_reg (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  cpfp_pkg::cpfp_result_type load_data,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output logic                      free,
   output cpfp_pkg::cpfp_result_type rsp_data
);

   logic                      valid_ff, valid_in;
   cpfp_pkg::cpfp_result_type data_ff;

   assign free      = !valid_ff || rsp_ready;
   assign valid_in  = load ? 1'b1 : (valid_ff && !rsp_ready);
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

endmodule

/* rtl/core/checksummed_position_frame_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Checksummed position frame parser
// Parses header / payload / checksum / tail frames from a serial byte stream
// and reports the position, span value and held signed deltas of good frames.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel carries one received serial byte per word (valid/ready).
//   The parser looks for header 0xA5, takes payload_len payload bytes, at
//   least six, while summing them modulo 256, then expects a checksum equal
//   to the sum and a tail of 0x5A. A good frame yields one word on the rsp
//   channel; bad frames are dropped without any output.
//   Path: a word is captured in the input register when it is accepted and
//   parsed from there, and the parse of a good tail loads the result register,
//   which drives the rsp channel.
//   Throughput: one word per cycle, set by the single pass from the input
//   register to the result register, unless that register is full at a good tail.
//   When the receiver stalls with a result pending, words that do not close
//   a good frame keep flowing; a good tail word waits in the input register
//   until the result register frees up, and req_ready drops in the meantime.
//   Reset clears the parser to the hunt phase, zeroes the held deltas,
//   empties both registers and sets payload_len to 6.
//   csr_write_en with csr_write_data writes payload_len; write only when idle.
// ----------------------------------------------------------------------------
module checksummed_position_frame_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [15:0]        rsp_pos_x,
   output logic [15:0]        rsp_pos_y,
   output logic [15:0]        rsp_span_value,
   output logic signed [15:0] rsp_delta_x_out,
   output logic signed [15:0] rsp_delta_y_out,
   output logic               rsp_x_updated,
   output logic               rsp_y_updated,
   input  logic               csr_write_en,
   input  logic [7:0]         csr_write_data
);

   // Input register, holding the word waiting to be parsed.
   logic       in_vld_ff, in_vld_in;
   logic [7:0] in_byte_ff;
   logic       req_take;
   logic       proc_go;
   logic       out_free;
   logic [7:0] payload_len_ff;

   cpfp_pkg::cpfp_result_type parse_res;
   cpfp_pkg::cpfp_result_type out_res;

   // A word is parsed unless it is a good tail and the result register is full.
   assign proc_go   = in_vld_ff && (!parse_res.emit || out_free);
   assign req_ready = !in_vld_ff || proc_go;
   assign req_take  = req_valid && req_ready;
   assign in_vld_in = req_take ? 1'b1 : (in_vld_ff && !proc_go);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff      <= 1'b0;
         payload_len_ff <= cpfp_pkg::PAYLOAD_LEN_RESET;
      end else begin
         in_vld_ff <= in_vld_in;
         if (csr_write_en) begin
            payload_len_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   cpfp_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .go          (proc_go),
      .rx_byte     (in_byte_ff),
      .payload_len (payload_len_ff),
      .res         (parse_res)
   );

   cpfp_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (proc_go && parse_res.emit),
      .load_data (parse_res),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .free      (out_free),
      .rsp_data  (out_res)
   );

   assign rsp_pos_x       = out_res.pos_x;
   assign rsp_pos_y       = out_res.pos_y;
   assign rsp_span_value  = out_res.span_value;
   assign rsp_delta_x_out = out_res.delta_x_out;
   assign rsp_delta_y_out = out_res.delta_y_out;
   assign rsp_x_updated   = out_res.x_updated;
   assign rsp_y_updated   = out_res.y_updated;

   // A finished frame always lands in the result register.
   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (proc_go && parse_res.emit) |=> rsp_valid)
      else $error("finished frame did not reach the result register");

   // A pending result that is not taken is never overwritten.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !(proc_go && parse_res.emit))
      else $error("pending result overwritten");

   // A held word that is not parsed stays held.
   a_hold_word: assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && !proc_go) |=> (in_vld_ff && $stable(in_byte_ff)))
      else $error("stalled input word lost");

endmodule

/* dv/tb_checksummed_position_frame_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Checksummed position frame parser testbench
// Streams serial bytes into the parser and checks every decoded frame against
// a behavioral parser that runs on the words the block accepts. The stream
// mixes good frames, bad checksums, bad tails, stray bytes and frame length
// changes, some of them while a frame is being collected.
// ----------------------------------------------------------------------------
module tb_checksummed_position_frame_parser;

   // Before a length write or a drain pause the driver waits for SETTLE_CYCLES
   // quiet cycles with nothing in flight.
   localparam int SETTLE_CYCLES    = 4;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int BYTE_TARGET      = 1560;

   // Entries of the stimulus queue: a serial byte, a length write, a pause
   // until every frame has come back, or a request for a long receiver hold.
   typedef enum logic [1:0] {
      OP_BYTE,
      OP_LEN_WRITE,
      OP_DRAIN,
      OP_HOLD
   } stream_op_type;

   typedef enum logic [1:0] {
      FAULT_NONE,
      FAULT_SUM,
      FAULT_TAIL
   } frame_fault_type;

   typedef struct {
      stream_op_type op;
      logic [7:0]    value;
      int            gap;
      int            stall_max;
   } stream_item_type;

   logic               clock          = 1'b0;
   logic               reset          = 1'b1;
   logic               req_valid      = 1'b0;
   logic               req_ready;
   logic [7:0]         req_rx_byte    = 8'h00;
   logic               rsp_valid;
   logic               rsp_ready      = 1'b0;
   logic [15:0]        rsp_pos_x;
   logic [15:0]        rsp_pos_y;
   logic [15:0]        rsp_span_value;
   logic signed [15:0] rsp_delta_x_out;
   logic signed [15:0] rsp_delta_y_out;
   logic               rsp_x_updated;
   logic               rsp_y_updated;
   logic               csr_write_en   = 1'b0;
   logic [7:0]         csr_write_data = 8'h00;

   checksummed_position_frame_parser i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y),
      .rsp_span_value  (rsp_span_value),
      .rsp_delta_x_out (rsp_delta_x_out),
      .rsp_delta_y_out (rsp_delta_y_out),
      .rsp_x_updated   (rsp_x_updated),
      .rsp_y_updated   (rsp_y_updated),
      .csr_write_en    (csr_write_en),
      .csr_write_data  (csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Behavioral parser. It tracks the block's phase, byte count, running sum,
   // the six held field bytes, the held deltas and its own copy of the length
   // register, and it queues one expected frame for each good tail.
   // -------------------------------------------------------------------------
   cpfp_pkg::cpfp_phase_type  parse_phase = cpfp_pkg::PH_HUNT;
   logic [7:0]                parse_count = 8'd0;
   logic [7:0]                parse_sum   = 8'd0;
   logic [7:0]                field_hold [0:5] = '{default: 8'h00};
   logic [15:0]               held_x_track = 16'h0000;
   logic [15:0]               held_y_track = 16'h0000;
   logic [7:0]                frame_len_reg = cpfp_pkg::PAYLOAD_LEN_RESET;
   cpfp_pkg::cpfp_result_type good_frame_q [$];

   task automatic parse_rx_byte(input logic [7:0] rx);
      logic [7:0]                len_now;
      cpfp_pkg::cpfp_result_type frame;
      // A length below six still collects all six field bytes.
      len_now = (frame_len_reg < cpfp_pkg::FIELD_COUNT) ? cpfp_pkg::FIELD_COUNT
                                                        : frame_len_reg;
      case (parse_phase)
         cpfp_pkg::PH_HUNT: begin
            if (rx == cpfp_pkg::HEADER_BYTE) begin
               parse_count = 8'd0;
               parse_sum   = 8'd0;
               parse_phase = cpfp_pkg::PH_PAYLOAD;
            end
         end
         cpfp_pkg::PH_PAYLOAD: begin
            if (parse_count < cpfp_pkg::FIELD_COUNT) field_hold[parse_count] = rx;
            parse_sum   = parse_sum + rx;
            // The count is 8 bits wide, so a length lowered below the count
            // mid-frame is only reached again after the count wraps.
            parse_count = parse_count + 8'd1;
            if (parse_count == len_now) parse_phase = cpfp_pkg::PH_CHECK;
         end
         cpfp_pkg::PH_CHECK: begin
            if (rx == parse_sum) begin
               parse_phase = cpfp_pkg::PH_TAIL;
               parse_count = 8'd0;
            end else begin
               // The failing byte is consumed here and never seen as a header.
               parse_phase = cpfp_pkg::PH_HUNT;
               parse_count = 8'd0;
               parse_sum   = 8'd0;
            end
         end
         default: begin
            parse_phase = cpfp_pkg::PH_HUNT;
            parse_count = 8'd0;
            parse_sum   = 8'd0;
            if (rx == cpfp_pkg::TAIL_BYTE) begin
               frame.emit        = 1'b1;
               frame.pos_x       = {field_hold[0], field_hold[1]};
               frame.pos_y       = {field_hold[2], field_hold[3]};
               frame.span_value  = {field_hold[4], field_hold[5]};
               frame.x_updated   = (frame.pos_x != cpfp_pkg::ABSENT_POS);
               frame.y_updated   = (frame.pos_y != cpfp_pkg::ABSENT_POS);
               if (frame.x_updated) held_x_track = frame.pos_x;
               if (frame.y_updated) held_y_track = frame.pos_y;
               frame.delta_x_out = held_x_track;
               frame.delta_y_out = held_y_track;
               good_frame_q.push_back(frame);
            end
         end
      endcase
   endtask

   // -------------------------------------------------------------------------
   // Stimulus queue and the helpers that fill it.
   // -------------------------------------------------------------------------
   stream_item_type stream_q [$];
   int              send_gap_max = 12;
   int              stall_gap_max = 12;
   int              bytes_queued = 0;
   int              cur_len = 6;

   task automatic push_byte(input logic [7:0] v);
      stream_item_type item;
      item.op        = OP_BYTE;
      item.value     = v;
      item.gap       = $urandom_range(0, send_gap_max);
      item.stall_max = stall_gap_max;
      stream_q.push_back(item);
      bytes_queued++;
   endtask

   task automatic push_op(input stream_op_type op, input logic [7:0] v);
      stream_item_type item;
      item.op        = op;
      item.value     = v;
      item.gap       = 0;
      item.stall_max = stall_gap_max;
      stream_q.push_back(item);
   endtask

   task automatic set_len(input logic [7:0] v);
      push_op(OP_LEN_WRITE, v);
      cur_len = int'((v < cpfp_pkg::FIELD_COUNT) ? cpfp_pkg::FIELD_COUNT : v);
   endtask

   // Picks whether the sender, the receiver, both or neither idle for a while.
   task automatic set_idle_style();
      int style;
      style         = $urandom_range(0, 3);
      send_gap_max  = style[0] ? 12 : 0;
      stall_gap_max = style[1] ? 12 : 0;
   endtask

   // Queues one frame of len_total payload bytes. A length write can be put
   // in after split_at payload bytes, which changes the length mid-frame.
   task automatic push_frame(input int len_total, input logic [15:0] x,
                             input logic [15:0] y, input logic [15:0] span,
                             input frame_fault_type fault, input logic [7:0] bad_value,
                             input int split_at = -1, input logic [7:0] split_len = 8'd0);
      logic [7:0] sum;
      logic [7:0] pb;
      sum = 8'h00;
      push_byte(cpfp_pkg::HEADER_BYTE);
      for (int i = 0; i < len_total; i++) begin
         if (i == split_at) set_len(split_len);
         case (i)
            0:       pb = x[15:8];
            1:       pb = x[7:0];
            2:       pb = y[15:8];
            3:       pb = y[7:0];
            4:       pb = span[15:8];
            5:       pb = span[7:0];
            default: pb = 8'($urandom_range(0, 255));
         endcase
         sum = sum + pb;
         push_byte(pb);
      end
      if (fault == FAULT_SUM) begin
         push_byte((bad_value == sum) ? sum + 8'd1 : bad_value);
      end else begin
         push_byte(sum);
         if (fault == FAULT_TAIL) begin
            push_byte((bad_value == cpfp_pkg::TAIL_BYTE) ? cpfp_pkg::HEADER_BYTE
                                                         : bad_value);
         end else begin
            push_byte(cpfp_pkg::TAIL_BYTE);
         end
      end
   endtask

   // A frame with random content at the current length, now and then with a
   // fault or a few stray bytes in front of it.
   task automatic random_frame();
      logic [15:0]     x;
      logic [15:0]     y;
      int              dice;
      frame_fault_type fault;
      x     = ($urandom_range(0, 4) == 0) ? cpfp_pkg::ABSENT_POS : 16'($urandom);
      y     = ($urandom_range(0, 4) == 0) ? cpfp_pkg::ABSENT_POS : 16'($urandom);
      dice  = $urandom_range(0, 9);
      fault = (dice == 0) ? FAULT_SUM : (dice == 1) ? FAULT_TAIL : FAULT_NONE;
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
      end
      push_frame(cur_len, x, y, 16'($urandom), fault, 8'($urandom_range(0, 255)));
   endtask

   // -------------------------------------------------------------------------
   // Driver. It offers one word at a time, keeps valid and the byte steady
   // until the word is taken, and feeds every accepted word to the parser
   // model. Length writes and drain pauses wait until the block is quiet.
   // -------------------------------------------------------------------------
   int recv_gap_max  = 12;
   int hold_requests = 0;
   int quiet_cycles  = 0;
   int bytes_sent    = 0;
   int len_writes    = 0;

   always @(posedge clock) begin : driver
      logic       offer;
      logic [7:0] offer_byte;
      logic       write_len;
      if (reset) begin
         req_valid    <= 1'b0;
         csr_write_en <= 1'b0;
         quiet_cycles = 0;
      end else begin
         offer      = 1'b0;
         offer_byte = req_rx_byte;
         write_len  = 1'b0;
         if (req_valid && req_ready) begin
            parse_rx_byte(req_rx_byte);
            bytes_sent++;
         end
         if (req_valid && !req_ready) begin
            // The word is still waiting; keep it on the bus.
            offer = 1'b1;
         end else if (stream_q.size() != 0) begin
            case (stream_q[0].op)
               OP_BYTE: begin
                  if (stream_q[0].gap > 0) begin
                     stream_q[0].gap = stream_q[0].gap - 1;
                  end else begin
                     offer        = 1'b1;
                     offer_byte   = stream_q[0].value;
                     recv_gap_max = stream_q[0].stall_max;
                     void'(stream_q.pop_front());
                  end
               end
               OP_LEN_WRITE: begin
                  if (quiet_cycles >= SETTLE_CYCLES) begin
                     write_len     = 1'b1;
                     csr_write_data <= stream_q[0].value;
                     // No word is offered before the write lands, so the model
                     // may take the new length right away.
                     frame_len_reg = stream_q[0].value;
                     len_writes++;
                     void'(stream_q.pop_front());
                  end
               end
               OP_DRAIN: begin
                  if (quiet_cycles >= SETTLE_CYCLES) void'(stream_q.pop_front());
               end
               default: begin
                  hold_requests++;
                  void'(stream_q.pop_front());
               end
            endcase
         end
         quiet_cycles = (offer || good_frame_q.size() != 0) ? 0 : quiet_cycles + 1;
         req_valid    <= offer;
         if (offer) req_rx_byte <= offer_byte;
         csr_write_en <= write_len;
      end
   end

   // -------------------------------------------------------------------------
   // Monitor. It compares every accepted result word with the oldest expected
   // frame, then draws how long to hold ready low before the next one. A hold
   // request from the driver starts a long stall that is counted here.
   // -------------------------------------------------------------------------
   int errors         = 0;
   int frames_checked = 0;
   int stall_left     = 0;
   int holds_started  = 0;

   task automatic compare_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: frame %0d %s expected %h actual %h", $time, frames_checked,
                  name, want, got);
      end
   endtask

   task automatic check_frame();
      cpfp_pkg::cpfp_result_type want;
      if (good_frame_q.size() == 0) begin
         errors++;
         $display("%0t: unexpected frame expected none actual pos_x %h pos_y %h span %h",
                  $time, rsp_pos_x, rsp_pos_y, rsp_span_value);
      end else begin
         want = good_frame_q.pop_front();
         compare_field("pos_x", want.pos_x, rsp_pos_x);
         compare_field("pos_y", want.pos_y, rsp_pos_y);
         compare_field("span_value", want.span_value, rsp_span_value);
         compare_field("delta_x_out", want.delta_x_out, rsp_delta_x_out);
         compare_field("delta_y_out", want.delta_y_out, rsp_delta_y_out);
         compare_field("x_updated", 16'(want.x_updated), 16'(rsp_x_updated));
         compare_field("y_updated", 16'(want.y_updated), 16'(rsp_y_updated));
         frames_checked++;
      end
   endtask

   always @(posedge clock) begin : monitor
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            check_frame();
            stall_left = $urandom_range(0, recv_gap_max);
         end else if (stall_left > 0) begin
            stall_left--;
         end
         if (holds_started != hold_requests) begin
            holds_started = hold_requests;
            stall_left    = LONG_HOLD_CYCLES;
         end
         rsp_ready <= (stall_left == 0);
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus, reset and end of run.
   // -------------------------------------------------------------------------
   initial begin
      int pick;

      // Directed opening at the reset length of six. Both positions absent, so
      // nothing is updated and the held deltas stay at zero.
      push_frame(6, cpfp_pkg::ABSENT_POS, cpfp_pkg::ABSENT_POS, 16'h0000, FAULT_NONE,
                 8'h00);
      // Signed extremes, with header and tail values inside the payload.
      push_frame(6, 16'h8000, 16'h7FFF, 16'hA55A, FAULT_NONE, 8'h00);
      // A bad checksum that happens to equal the header byte; it is consumed
      // and must not start a frame.
      push_frame(6, 16'h0001, cpfp_pkg::ABSENT_POS, 16'hFFFF, FAULT_SUM,
                 cpfp_pkg::HEADER_BYTE);
      // A bad tail that equals the header byte, dropped in the same way.
      push_frame(6, 16'h0000, 16'h0000, 16'h1234, FAULT_TAIL, cpfp_pkg::HEADER_BYTE);

      // Pressure: wait for every result, then stall the receiver for a long
      // time while gapless frames keep coming, so the block backs up.
      push_op(OP_DRAIN, 8'h00);
      push_op(OP_HOLD, 8'h00);
      send_gap_max  = 0;
      stall_gap_max = 0;
      repeat (40) random_frame();

      // Length changes while a frame is being collected: lowered below the
      // count (the count wraps), raised, and lowered under six.
      set_idle_style();
      set_len(8'd20);
      push_frame(264, 16'($urandom), 16'($urandom), 16'($urandom), FAULT_NONE, 8'h00,
                 10, 8'd8);
      cur_len = 8;
      set_len(8'd6);
      push_frame(12, 16'($urandom), 16'($urandom), 16'($urandom), FAULT_NONE, 8'h00,
                 3, 8'd12);
      set_len(8'd9);
      push_frame(262, 16'($urandom), 16'($urandom), 16'($urandom), FAULT_NONE, 8'h00,
                 7, 8'd0);

      // The longest frames, one each.
      set_idle_style();
      set_len(8'd250);
      random_frame();
      set_len(8'd255);
      random_frame();

      // Random phases, mostly short lengths.
      while (bytes_queued < BYTE_TARGET) begin
         pick = $urandom_range(0, 99);
         if (pick < 25) set_len(8'($urandom_range(0, 5)));
         else if (pick < 85) set_len(8'($urandom_range(6, 16)));
         else set_len(8'($urandom_range(17, 40)));
         set_idle_style();
         repeat ($urandom_range(8, 15)) random_frame();
         if ($urandom_range(0, 3) == 0) push_op(OP_DRAIN, 8'h00);
      end
      set_len(cpfp_pkg::PAYLOAD_LEN_RESET);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      @(posedge clock);
      while (stream_q.size() != 0 || req_valid || good_frame_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);

      $display("Sent %0d bytes and checked %0d frames over %0d length writes,",
               bytes_sent, frames_checked, len_writes);
      $display("including faults, mid-frame length changes and a long receiver stall.");
      if (errors == 0) begin
         $display("tb_checksummed_position_frame_parser OK");
      end else begin
         $display("tb_checksummed_position_frame_parser NOT OK");
      end
      $finish;
   end

   // Safety net far beyond the slowest legal run.
   initial begin
      #3000000;
      $display("Timeout with %0d frames still expected.", good_frame_q.size());
      $display("tb_checksummed_position_frame_parser NOT OK");
      $finish;
   end

endmodule
